@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GGD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GGD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/ggd_pkg.sv @@
`timescale 1ns / 1ps
package ggd_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP_FWD   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI_FWD   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD_FWD   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KP_ANG   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KI_ANG   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KD_ANG   = 4'd7;

  localparam int STANDOFF_DIST_DEF = 0;
  localparam int STOP_RADIUS_DEF   = 655;

  localparam int DELTA_W  = 25;  // target minus position
  localparam int CRD_W    = 43;  // CORDIC x and y
  localparam int ANG_W    = 20;  // CORDIC z, Q.16 radians
  localparam int CRD_STEPS = 17;
  localparam int ROOT_W   = 25;
  localparam int RAD_W    = 50;
  localparam int AERR_W   = 19;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [AERR_W-1:0] PI_Q13     = 19'sd25736;
  localparam logic signed [AERR_W-1:0] TWO_PI_Q13 = 19'sd51472;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQ   = 6'b000010,
    S_ROOT = 6'b000100,
    S_INT  = 6'b001000,
    S_MAC  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  // Control from the sequencer to the CORDIC unit
  typedef struct packed {
    logic       load;
    logic       step;
    logic [4:0] idx;
  } crd_ctl_t;

  // Arctangent of 2^-i in Q.16 radians
  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 20'sd51472;
      5'd1:  v = 20'sd30386;
      5'd2:  v = 20'sd16055;
      5'd3:  v = 20'sd8150;
      5'd4:  v = 20'sd4091;
      5'd5:  v = 20'sd2047;
      5'd6:  v = 20'sd1024;
      5'd7:  v = 20'sd512;
      5'd8:  v = 20'sd256;
      5'd9:  v = 20'sd128;
      5'd10: v = 20'sd64;
      5'd11: v = 20'sd32;
      5'd12: v = 20'sd16;
      5'd13: v = 20'sd8;
      5'd14: v = 20'sd4;
      5'd15: v = 20'sd2;
      5'd16: v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ggd_cordic.sv @@
`timescale 1ns / 1ps
module ggd_cordic (
  input  logic                                 clk,
  input  ggd_pkg::crd_ctl_t                    ctl,
  input  logic signed [ggd_pkg::DELTA_W-1:0]   dx,
  input  logic signed [ggd_pkg::DELTA_W-1:0]   dy,
  output logic signed [ggd_pkg::ANG_W-1:0]     z
);
  import ggd_pkg::*;

  logic signed [CRD_W-1:0] x_r, y_r, x_nxt, y_nxt, x0, y0, xs, ys;
  logic signed [ANG_W-1:0] z_r, z_nxt;

  always_comb begin
    x0 = $signed({{(CRD_W-DELTA_W-16){dx[DELTA_W-1]}}, dx, 16'b0});
    y0 = $signed({{(CRD_W-DELTA_W-16){dy[DELTA_W-1]}}, dy, 16'b0});
    xs = x_r >>> ctl.idx;
    ys = y_r >>> ctl.idx;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctl.load) begin
      // rotate the left half-plane by 90 degrees first
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x_nxt = y0;
          y_nxt = -x0;
          z_nxt = HALF_PI_Q16;
        end else begin
          x_nxt = -y0;
          y_nxt = x0;
          z_nxt = -HALF_PI_Q16;
        end
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
    end else if (ctl.step) begin
      // one vectoring micro-rotation toward y = 0
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_q16(ctl.idx);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_q16(ctl.idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign z = z_r;

endmodule

@@ rtl/goto_goal_dual_pid.sv @@
`timescale 1ns / 1ps
// Go-to-goal controller with a forward and a steering PID loop.
// Input channel in_*: one pose sample per item (x, y, heading).
// Output channel out_*: one result item per input item with both commands,
// the distance, the forward error, the bearing error and the arrived flag.
// Configuration: cfg_we writes cfg_data into register cfg_idx (goal point
// and six gains); write only while no item is in flight.
// Steps per item: the squares on the shared multiplier, 25 square-root
// digits (one per cycle) with the 17 CORDIC steps running beside them, the
// integrator step, the six PID products on the shared multiplier and the
// output load. After arrival the multiply phase is skipped.
// in_tready is high only while the sequencer is idle, so a new sample is
// taken only after the last one has left the final step. The output
// register holds a result until taken; the block takes and works on a new
// sample meanwhile, but a stalled receiver holds that next item in its
// final step, where no new sample is taken.
// Reset (rst_n low, synchronous) clears the configuration registers, the
// sequencer, PID state, arrived and the output valid.
module goto_goal_dual_pid #(
  parameter int STANDOFF_DIST = ggd_pkg::STANDOFF_DIST_DEF,
  parameter int STOP_RADIUS   = ggd_pkg::STOP_RADIUS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ggd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ggd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x [23:0], pos_y [47:24], heading [63:48]
  input  logic [63:0]                        in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // fwd_cmd [18:0], turn_cmd [42:19], goal_dist [66:43], fwd_err [90:67],
  // ang_err [106:91], arrived [107], zero [111:108]
  output logic [111:0]                       out_tdata
);
  import ggd_pkg::*;

  // configuration registers
  logic signed [23:0] tgt_x_r, tgt_y_r;
  logic [15:0] kp_f_r, ki_f_r, kd_f_r, kp_a_r, ki_a_r, kd_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_x_r <= '0; tgt_y_r <= '0;
      kp_f_r <= '0; ki_f_r <= '0; kd_f_r <= '0;
      kp_a_r <= '0; ki_a_r <= '0; kd_a_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET_X: tgt_x_r <= cfg_data;
        REG_TARGET_Y: tgt_y_r <= cfg_data;
        REG_KP_FWD:   kp_f_r  <= cfg_data[15:0];
        REG_KI_FWD:   ki_f_r  <= cfg_data[15:0];
        REG_KD_FWD:   kd_f_r  <= cfg_data[15:0];
        REG_KP_ANG:   kp_a_r  <= cfg_data[15:0];
        REG_KI_ANG:   ki_a_r  <= cfg_data[15:0];
        REG_KD_ANG:   kd_a_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic in_acc;

  logic signed [DELTA_W-1:0] dx_r, dy_r, dx_in, dy_in;
  logic signed [15:0] head_r;
  logic [RAD_W-1:0] rad_r;
  logic [ROOT_W+1:0] rem_r, rem_sh, trial;
  logic [ROOT_W-1:0] root_r;
  logic signed [58:0] prod_r;
  logic signed [25:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] acc_r, acc_nxt;

  logic signed [23:0] ferr_r, last_f_r;
  logic signed [AERR_W-1:0] aerr_r, last_a_r;
  logic signed [31:0] fint_r, aint_r;
  logic done_r;
  logic signed [18:0] fcmd_r;
  logic signed [23:0] tcmd_r;

  logic out_valid_r;
  logic [111:0] out_data_r;

  crd_ctl_t crd_ctl;
  logic signed [ANG_W-1:0] crd_z;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign dx_in = $signed({tgt_x_r[23], tgt_x_r}) - $signed({in_tdata[23], in_tdata[23:0]});
  assign dy_in = $signed({tgt_y_r[23], tgt_y_r}) - $signed({in_tdata[47], in_tdata[47:24]});

  assign crd_ctl.load = in_acc;
  assign crd_ctl.step = (state_r == S_ROOT) && (cnt_r < 5'(CRD_STEPS));
  assign crd_ctl.idx  = cnt_r;

  ggd_cordic u_cordic (
    .clk (clk),
    .ctl (crd_ctl),
    .dx  (dx_in),
    .dy  (dy_in),
    .z   (crd_z)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQ) begin
      mul_a = (cnt_r == 5'd0) ? 26'(dx_r) : 26'(dy_r);
      mul_b = (cnt_r == 5'd0) ? 33'(dx_r) : 33'(dy_r);
    end else if (state_r == S_MAC) begin
      case (cnt_r)
        5'd0: begin mul_a = $signed({10'b0, kp_f_r}); mul_b = 33'(ferr_r); end
        5'd1: begin mul_a = $signed({10'b0, ki_f_r}); mul_b = 33'(fint_r); end
        5'd2: begin
          mul_a = $signed({10'b0, kd_f_r});
          mul_b = 33'(ferr_r) - 33'(last_f_r);
        end
        5'd3: begin mul_a = $signed({10'b0, kp_a_r}); mul_b = 33'(aerr_r); end
        5'd4: begin mul_a = $signed({10'b0, ki_a_r}); mul_b = 33'(aint_r); end
        5'd5: begin
          mul_a = $signed({10'b0, kd_a_r});
          mul_b = 33'(aerr_r) - 33'(last_a_r);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // square root digit
  assign rem_sh = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  // error terms after the root and the bearing are done
  logic signed [25:0] fdiff;
  logic signed [23:0] ferr_c;
  logic signed [20:0] zr;
  logic signed [AERR_W-1:0] bear, aerr_c, aerr_w;
  logic signed [32:0] fint_s, aint_s;
  logic signed [31:0] fint_c, aint_c;

  always_comb begin
    fdiff = $signed({1'b0, root_r}) - 26'(STANDOFF_DIST);
    if (fdiff > 26'sd8388607)       ferr_c = 24'sd8388607;
    else if (fdiff < -26'sd8388608) ferr_c = -24'sd8388608;
    else                            ferr_c = fdiff[23:0];
    zr = 21'(crd_z) + 21'sd4;
    bear = (dx_r == '0 && dy_r == '0) ? '0 : AERR_W'(zr >>> 3);
    aerr_c = bear - AERR_W'(head_r);
    aerr_w = aerr_c;
    if (aerr_c < -PI_Q13) aerr_w = aerr_c + TWO_PI_Q13;
    else if (aerr_c > PI_Q13) aerr_w = aerr_c - TWO_PI_Q13;
    fint_s = 33'(fint_r) + 33'(ferr_c);
    aint_s = 33'(aint_r) + 33'(aerr_w);
    fint_c = (fint_s[32] != fint_s[31]) ? {fint_s[32], {31{~fint_s[32]}}} : fint_s[31:0];
    aint_c = (aint_s[32] != aint_s[31]) ? {aint_s[32], {31{~aint_s[32]}}} : aint_s[31:0];
  end

  // command clamps
  logic signed [50:0] fsh, tsh;
  logic signed [18:0] fcmd_c;
  logic signed [23:0] tcmd_c;
  always_comb begin
    acc_nxt = ((cnt_r == 5'd1 || cnt_r == 5'd4) ? 51'sd0 : acc_r) + 51'(prod_r);
    fsh = acc_nxt >>> 8;
    tsh = acc_nxt >>> 5;
    if (fsh > 51'sd131072)       fcmd_c = 19'sd131072;
    else if (fsh < -51'sd131072) fcmd_c = -19'sd131072;
    else                         fcmd_c = fsh[18:0];
    if (tsh > 51'sd8388607)       tcmd_c = 24'sd8388607;
    else if (tsh < -51'sd8388608) tcmd_c = -24'sd8388608;
    else                          tcmd_c = tsh[23:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r + 5'd1;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) state_nxt = S_SQ;
      end
      S_SQ: if (cnt_r == 5'd2) begin
        state_nxt = S_ROOT;
        cnt_nxt = '0;
      end
      S_ROOT: if (cnt_r == 5'(ROOT_W-1)) begin
        state_nxt = S_INT;
        cnt_nxt = '0;
      end
      S_INT: begin
        state_nxt = done_r ? S_FIN : S_MAC;
        cnt_nxt = '0;
      end
      S_MAC: if (cnt_r == 5'd6) state_nxt = S_FIN;
      S_FIN: begin
        cnt_nxt = '0;
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      done_r <= 1'b0;
      fint_r <= '0; aint_r <= '0;
      last_f_r <= '0; last_a_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      // latch the sample
      if (in_acc) begin
        dx_r <= dx_in;
        dy_r <= dy_in;
        head_r <= $signed(in_tdata[63:48]);
      end
      // sum the squares
      if (state_r == S_SQ) begin
        if (cnt_r == 5'd1) rad_r <= prod_r[RAD_W-1:0];
        if (cnt_r == 5'd2) begin
          rad_r <= rad_r + prod_r[RAD_W-1:0];
          rem_r <= '0;
          root_r <= '0;
        end
      end
      // one root digit per cycle
      if (state_r == S_ROOT) begin
        rad_r <= rad_r << 2;
        if (rem_sh >= trial) begin
          rem_r <= rem_sh - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      // errors and integrators
      if (state_r == S_INT) begin
        ferr_r <= ferr_c;
        aerr_r <= aerr_w;
        if (!done_r) begin
          fint_r <= fint_c;
          aint_r <= aint_c;
        end
      end
      // accumulate the PID products
      if (state_r == S_MAC) begin
        if (cnt_r != 5'd0) acc_r <= acc_nxt;
        if (cnt_r == 5'd3) fcmd_r <= fcmd_c;
        if (cnt_r == 5'd6) begin
          tcmd_r <= tcmd_c;
          last_f_r <= ferr_r;
          last_a_r <= aerr_r;
          if ({7'b0, root_r} <= 32'(STOP_RADIUS)) done_r <= 1'b1;
        end
      end
      // load the output register
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r <= {4'b0, done_r, aerr_r[15:0], ferr_r,
                       root_r[ROOT_W-1] ? 24'hFFFFFF : root_r[23:0],
                       done_r ? 24'd0 : tcmd_r,
                       done_r ? 19'd0 : fcmd_r};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/ggd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ggd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata
);
  // a stalled result stays offered
  `GGD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // a stalled result keeps its bits
  `GGD_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))
  // one item at a time: busy right after an accept
  `GGD_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready)
  // arrived forces both commands to zero
  `GGD_ASSERT_IMP(a_arrived_zero, out_tvalid && out_tdata[107],
                  out_tdata[42:0] == 43'd0)
  // forward command stays within plus or minus 2.0
  `GGD_ASSERT_IMP(a_fwd_lim, out_tvalid,
                  (!out_tdata[18] && out_tdata[17:0] <= 18'd131072) ||
                  (out_tdata[18] && out_tdata[17:0] >= 18'd131072))
endmodule

bind goto_goal_dual_pid ggd_checker u_ggd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import ggd_pkg::*;

  localparam int STANDOFF    = 0;
  localparam int STOP_RADIUS = 655;
  localparam int WATCHDOG    = 4000;
  localparam int DRAIN       = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;
  localparam longint PI_Q13_L   = 25736;
  localparam longint TWOPI_Q13L = 51472;
  localparam longint HPI_Q16_L  = 102944;
  localparam longint FWD_LIM    = 131072;

  typedef struct {
    logic signed [18:0] fwd_cmd;
    logic signed [23:0] turn_cmd;
    logic [23:0]        goal_dist;
    logic signed [23:0] fwd_err;
    logic signed [15:0] ang_err;
    logic               arrived;
  } ctrl_out_t;

  typedef struct {
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] hd;
    bit          typed;
    ctrl_out_t   want;
  } pose_row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [3:0]   cfg_idx;
  logic [23:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  // pos_x [23:0], pos_y [47:24], heading [63:48]
  logic [63:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // fwd_cmd [18:0], turn_cmd [42:19], goal_dist [66:43], fwd_err [90:67],
  // ang_err [106:91], arrived [107], zero [111:108]
  logic [111:0] out_tdata;

  goto_goal_dual_pid DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Controller model state
  logic signed [23:0] goal_x, goal_y;
  logic [15:0] gain [2:7];
  longint prev_ferr, prev_aerr, fwd_acc, ang_acc;
  bit     stopped;

  ctrl_out_t pending_q [$];
  int  n_err, n_out, n_in, n_arrived_out, idle_cycles;
  bit  quiet;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arc_step(int i);
    longint tab [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                         128, 64, 32, 16, 8, 4, 2, 1};
    return tab[i];
  endfunction

  // Bearing of (dx, dy) in Q3.13 by vectoring rotation
  function automatic longint bearing(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HPI_Q16_L;
      end else begin
        t = x; x = -y; y = t; z = -HPI_Q16_L;
      end
    end
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += arc_step(i);
      end else begin
        x -= ys; y += xs; z -= arc_step(i);
      end
    end
    return (z + 4) >>> 3;
  endfunction

  // Advance the controller by one pose and return the command item
  function automatic ctrl_out_t control_step(logic [23:0] px, logic [23:0] py,
                                             logic [15:0] hd);
    ctrl_out_t r;
    longint dx, dy, gdist, ferr, aerr, sum, fcmd, tcmd;
    dx = longint'(goal_x) - longint'($signed(px));
    dy = longint'(goal_y) - longint'($signed(py));
    gdist = root_floor(longint'(dx * dx + dy * dy));
    ferr = clampl(gdist - STANDOFF, -8388608, 8388607);
    aerr = bearing(dx, dy) - longint'($signed(hd));
    if (aerr < -PI_Q13_L) aerr += TWOPI_Q13L;
    if (aerr > PI_Q13_L) aerr -= TWOPI_Q13L;
    fcmd = 0;
    tcmd = 0;
    if (!stopped) begin
      fwd_acc = clampl(fwd_acc + ferr, -64'sd2147483648, 64'sd2147483647);
      ang_acc = clampl(ang_acc + aerr, -64'sd2147483648, 64'sd2147483647);
      sum = longint'(gain[2]) * ferr + longint'(gain[3]) * fwd_acc
          + longint'(gain[4]) * (ferr - prev_ferr);
      fcmd = clampl(sum >>> 8, -FWD_LIM, FWD_LIM);
      sum = longint'(gain[5]) * aerr + longint'(gain[6]) * ang_acc
          + longint'(gain[7]) * (aerr - prev_aerr);
      tcmd = clampl(sum >>> 5, -8388608, 8388607);
      prev_ferr = ferr;
      prev_aerr = aerr;
      if (gdist <= STOP_RADIUS) stopped = 1'b1;
    end
    if (stopped) begin
      fcmd = 0;
      tcmd = 0;
    end
    r.fwd_cmd   = fcmd[18:0];
    r.turn_cmd  = tcmd[23:0];
    r.goal_dist = gdist > 64'hFFFFFF ? 24'hFFFFFF : gdist[23:0];
    r.fwd_err   = ferr[23:0];
    r.ang_err   = aerr[15:0];
    r.arrived   = stopped;
    return r;
  endfunction

  // Write one register while the block is idle
  task automatic write_reg(logic [3:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      REG_TARGET_X: goal_x = val;
      REG_TARGET_Y: goal_y = val;
      REG_KP_FWD, REG_KI_FWD, REG_KD_FWD,
      REG_KP_ANG, REG_KI_ANG, REG_KD_ANG: gain[idx] = val[15:0];
      default: ;
    endcase
  endtask

  // Drop the offer, then hold off until every expected item is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setup(logic [23:0] tx, logic [23:0] ty, logic [23:0] g [2:7]);
    drain();
    write_reg(REG_TARGET_X, tx);
    write_reg(REG_TARGET_Y, ty);
    write_reg(REG_KP_FWD, g[2]);
    write_reg(REG_KI_FWD, g[3]);
    write_reg(REG_KD_FWD, g[4]);
    write_reg(REG_KP_ANG, g[5]);
    write_reg(REG_KI_ANG, g[6]);
    write_reg(REG_KD_ANG, g[7]);
    write_reg(REG_UNUSED, 24'($urandom()));
  endtask

  // Offer one pose item and record its expected command item on accept
  task automatic send_pose(logic [23:0] px, logic [23:0] py, logic [15:0] hd,
                           bit typed, ctrl_out_t want);
    int gap;
    ctrl_out_t e;
    gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {hd, py, px};
    do @(posedge clk); while (!in_tready);
    e = control_step(px, py, hd);
    pending_q.push_back(typed ? want : e);
    n_in++;
  endtask

  task automatic walk_rows(pose_row_t rows []);
    foreach (rows[i]) send_pose(rows[i].px, rows[i].py, rows[i].hd,
                                rows[i].typed, rows[i].want);
  endtask

  // Random pose kept clear of the stop radius
  task automatic random_pose(int scale);
    logic [23:0] px, py;
    longint dx, dy;
    ctrl_out_t none;
    none = '{default: '0};
    do begin
      if (scale >= 24) begin
        px = 24'($urandom());
        py = 24'($urandom());
      end else begin
        px = goal_x - 24'($signed($urandom_range(0, (1 << scale) - 1)) - (1 << (scale - 1)));
        py = goal_y - 24'($signed($urandom_range(0, (1 << scale) - 1)) - (1 << (scale - 1)));
      end
      dx = longint'(goal_x) - longint'($signed(px));
      dy = longint'(goal_y) - longint'($signed(py));
    end while (dx >= -1000 && dx <= 1000 && dy >= -1000 && dy <= 1000);
    send_pose(px, py, 16'($urandom()), 1'b0, none);
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      random_pose($urandom_range(0, 3) == 0 ? 24 : $urandom_range(11, 23));
    end
    quiet = 1'b0;
  endtask

  // Receiver side: stall at random before each item
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      repeat (quiet ? 0 : $urandom_range(0, 9)) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic mismatch(string field, longint want, longint got);
    n_err++;
    if (n_err <= 10)
      $display("mismatch on item %0d, %s: expected %0d, got %0d", n_out, field, want, got);
  endtask

  // Compare each command item with the oldest expectation
  always @(posedge clk) begin
    ctrl_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        mismatch("unexpected item", 0, 1);
      end else begin
        e = pending_q.pop_front();
        if (out_tdata[18:0] !== e.fwd_cmd)
          mismatch("fwd_cmd", e.fwd_cmd, $signed(out_tdata[18:0]));
        if (out_tdata[42:19] !== e.turn_cmd)
          mismatch("turn_cmd", e.turn_cmd, $signed(out_tdata[42:19]));
        if (out_tdata[66:43] !== e.goal_dist)
          mismatch("goal_dist", e.goal_dist, out_tdata[66:43]);
        if (out_tdata[90:67] !== e.fwd_err)
          mismatch("fwd_err", e.fwd_err, $signed(out_tdata[90:67]));
        if (out_tdata[106:91] !== e.ang_err)
          mismatch("ang_err", e.ang_err, $signed(out_tdata[106:91]));
        if (out_tdata[107] !== e.arrived)
          mismatch("arrived", e.arrived, out_tdata[107]);
        if (out_tdata[111:108] !== 4'd0)
          mismatch("pad bits", 0, out_tdata[111:108]);
        if (out_tdata[107] === 1'b1) n_arrived_out++;
      end
      n_out++;
    end
  end

  // Abort when no item moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired with %0d items outstanding", pending_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    pose_row_t open_rows [];
    pose_row_t stop_rows [];
    logic [23:0] g [2:7];
    logic [23:0] tx;
    ctrl_out_t none, at_goal;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    quiet = 1'b0;
    n_err = 0; n_out = 0; n_in = 0; n_arrived_out = 0; idle_cycles = 0;
    goal_x = '0; goal_y = '0;
    foreach (gain[i]) gain[i] = '0;
    prev_ferr = 0; prev_aerr = 0; fwd_acc = 0; ang_acc = 0; stopped = 1'b0;
    none = '{default: '0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, field extremes, all quadrants, odd headings
    open_rows = '{
      '{24'h800000, 24'h800000, 16'h0000, 0, none},
      '{24'h7FFFFF, 24'h7FFFFF, 16'h6488, 0, none},
      '{24'h800000, 24'h7FFFFF, 16'h9B78, 0, none},
      '{24'h7FFFFF, 24'h800000, 16'h7FFF, 0, none},
      '{24'h010000, 24'h000000, 16'h8000, 0, none},
      '{24'hFF0000, 24'h000000, 16'h0000, 0, none},
      '{24'h000000, 24'h010000, 16'h0000, 0, none},
      '{24'h000000, 24'hFF0000, 16'hFFFF, 0, none},
      '{24'h000400, 24'hFFFC00, 16'h3244, 0, none},
      '{24'hFFFC00, 24'h000400, 16'hCDBC, 0, none}
    };
    walk_rows(open_rows);

    // Full-scale gains and a far goal: clamps and integral saturation
    foreach (g[i]) g[i] = 24'hFFFFFF;
    load_setup(24'h7FFFFF, 24'h800000, g);
    for (int i = 0; i < 300; i++) random_pose(24);

    // Zero gains, opposite corner
    foreach (g[i]) g[i] = 24'h000000;
    load_setup(24'h800000, 24'h7FFFFF, g);
    random_run(150);

    // Several random settings
    for (int k = 0; k < 4; k++) begin
      foreach (g[i]) g[i] = $urandom_range(0, 2) == 0 ? 24'($urandom_range(0, 64))
                                                      : 24'($urandom());
      load_setup(24'($urandom()), 24'($urandom()), g);
      random_run(250);
    end

    // Arrival: just outside, on the radius, then on the goal with the state frozen
    foreach (g[i]) g[i] = 24'($urandom());
    tx = 24'($urandom_range(0, 24'h3FFFFF));
    load_setup(tx, tx, g);
    at_goal = '{default: '0};
    at_goal.arrived = 1'b1;
    stop_rows = '{
      '{tx - 24'd656, tx, 16'h0000, 0, none},
      '{tx - 24'd655, tx, 16'h1000, 0, none},
      '{tx, tx, 16'h0000, 1, at_goal},
      '{tx, tx, 16'h03E8, 1, '{19'd0, 24'd0, 24'd0, 24'd0, -16'sd1000, 1'b1}}
    };
    walk_rows(stop_rows);
    random_run(60);

    @(negedge clk);
    in_tvalid <= 1'b0;
    drain();
    repeat (DRAIN) @(posedge clk);

    $display("%0d pose items sent, %0d command items checked, %0d after arrival",
             n_in, n_out, n_arrived_out);
    $display("%0d mismatches, %0d items still expected", n_err, pending_q.size());
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
